>>> sv/tirp_pkg.sv
package tirp_pkg;

  // Telnet command codes
  localparam logic [7:0] IAC_CODE  = 8'd255;
  localparam logic [7:0] DONT_CODE = 8'd254;
  localparam logic [7:0] DO_CODE   = 8'd253;
  localparam logic [7:0] WONT_CODE = 8'd252;
  localparam logic [7:0] WILL_CODE = 8'd251;
  localparam logic [7:0] SB_CODE   = 8'd250;
  localparam logic [7:0] SE_CODE   = 8'd240;

  // Accepted option reset values: echo and suppress go ahead
  localparam logic [7:0] OPT_A_RESET = 8'd1;
  localparam logic [7:0] OPT_B_RESET = 8'd3;

  // Configuration register indexes
  localparam logic CFG_OPT_A = 1'b0;
  localparam logic CFG_OPT_B = 1'b1;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Pending verb, stored as verb minus WILL
  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_t;

endpackage

>>> sv/telnet_iac_receive_parser.sv
// Telnet receive parser: strips IAC command sequences from a received byte
// stream and passes clean data bytes to the host, while WILL/DO option requests
// produce a reply (DO/WILL for the two accepted options, DONT/WONT otherwise).
// One byte is accepted per cycle while the input is not stalled; a byte lands in an
// input register and its result, if any, passes into the output register once that
// register is free or its result is taken. While a result waits to be taken,
// the input register takes one more byte and then stalls the input. Bytes that
// cause no result (commands, subnegotiation content) produce nothing on the
// output. The user must write the accepted option codes through the cfg port
// (index 0 and 1) only while the block is idle; the block does not enforce this.
module telnet_iac_receive_parser
  import tirp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] data_byte,
  output logic [7:0] reply_verb,
  output logic [7:0] reply_option,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_CMD    = 3'd2,
    PH_SUB    = 3'd3,
    PH_SUBIAC = 3'd4
  } phase_t;

  logic [7:0] opt_a;
  logic [7:0] opt_b;
  phase_t     phase;
  phase_t     phase_next;
  verb_t      pending_verb;
  verb_t      pending_verb_next;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  logic       emit;
  logic       kind_next;
  logic [7:0] data_next;
  logic [7:0] verb_next;
  logic [7:0] option_next;
  logic       ok;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign rx_stall  = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      opt_a <= OPT_A_RESET;
      opt_b <= OPT_B_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OPT_A: opt_a <= cfg_data;
        CFG_OPT_B: opt_b <= cfg_data;
        default:   opt_a <= opt_a;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!rx_stall) begin
      in_full <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  assign ok = (in_byte == opt_a) || (in_byte == opt_b);

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    emit              = 1'b0;
    kind_next         = KIND_DATA;
    data_next         = 8'd0;
    verb_next         = 8'd0;
    option_next       = 8'd0;
    unique case (phase)
      PH_IAC: begin
        priority if (in_byte == IAC_CODE) begin
          emit       = 1'b1;
          data_next  = in_byte;
          phase_next = PH_DATA;
        end else if (in_byte >= WILL_CODE && in_byte <= DONT_CODE) begin
          pending_verb_next = verb_t'(in_byte[1:0] - WILL_CODE[1:0]);
          phase_next        = PH_CMD;
        end else if (in_byte == SB_CODE) begin
          phase_next = PH_SUB;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_CMD: begin
        phase_next  = PH_DATA;
        kind_next   = KIND_REPLY;
        option_next = in_byte;
        unique case (pending_verb)
          VERB_WILL: begin
            emit      = 1'b1;
            verb_next = ok ? DO_CODE : DONT_CODE;
          end
          VERB_DO: begin
            emit      = 1'b1;
            verb_next = ok ? WILL_CODE : WONT_CODE;
          end
          default: emit = 1'b0;
        endcase
      end
      PH_SUB: begin
        if (in_byte == IAC_CODE) begin
          phase_next = PH_SUBIAC;
        end
      end
      PH_SUBIAC: begin
        phase_next = (in_byte == SE_CODE) ? PH_DATA : PH_SUB;
      end
      default: begin
        if (in_byte == IAC_CODE) begin
          phase_next = PH_IAC;
        end else begin
          emit      = 1'b1;
          data_next = in_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= VERB_WILL;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full && emit;
      if (in_full) begin
        phase        <= phase_next;
        pending_verb <= pending_verb_next;
      end
    end
  end

  // hold result payload while stalled
  always_ff @(posedge clk) begin
    if (advance && in_full && emit) begin
      out_kind     <= kind_next;
      data_byte    <= data_next;
      reply_verb   <= verb_next;
      reply_option <= option_next;
    end
  end

  a_reply_verb: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_REPLY |->
      reply_verb == WILL_CODE || reply_verb == WONT_CODE ||
      reply_verb == DO_CODE || reply_verb == DONT_CODE)
    else $error("reply verb out of range");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DATA |-> reply_verb == 8'd0 && reply_option == 8'd0)
    else $error("data result carries reply fields");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> in_full && out_valid)
    else $error("input stalled without a waiting result");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_full)
    else $error("result pending after reset");

endmodule

>>> tb/sv/tb_telnet_iac_receive_parser.sv
module tb_telnet_iac_receive_parser;
  import tirp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum logic [2:0] {
    RXP_DATA,
    RXP_IAC,
    RXP_CMD,
    RXP_SUB,
    RXP_SUBIAC
  } rx_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] verb;
    logic [7:0] option;
  } parser_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] data_byte;
  logic [7:0] reply_verb;
  logic [7:0] reply_option;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_OPT_A;
  logic [7:0] cfg_data = 8'd0;

  // Parser copy kept alongside the block
  rx_phase_t  parse_state = RXP_DATA;
  verb_t      last_verb = VERB_WILL;
  logic [7:0] accept_a = OPT_A_RESET;
  logic [7:0] accept_b = OPT_B_RESET;

  logic [7:0]     rx_backlog[$];
  parser_result_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        long_hold = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  event        hold_kick;

  telnet_iac_receive_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .data_byte    (data_byte),
    .reply_verb   (reply_verb),
    .reply_option (reply_option),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial forever #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("cycle %0d: mismatch: %s", cycle_count, what);
  endtask

  task automatic expect_reply(input logic [7:0] verb, input logic [7:0] option);
    parser_result_t r;
    r.kind = KIND_REPLY;
    r.data = 8'd0;
    r.verb = verb;
    r.option = option;
    expected_results.push_back(r);
  endtask

  task automatic expect_data(input logic [7:0] b);
    parser_result_t r;
    r.kind = KIND_DATA;
    r.data = b;
    r.verb = 8'd0;
    r.option = 8'd0;
    expected_results.push_back(r);
  endtask

  // Advance the parser copy by one received byte
  task automatic parse_rx_byte(input logic [7:0] b);
    logic       hit;
    logic [7:0] verb_ofs;
    hit = (b == accept_a) || (b == accept_b);
    verb_ofs = b - WILL_CODE;
    case (parse_state)
      RXP_IAC: begin
        if (b == IAC_CODE) begin
          expect_data(b);
          parse_state = RXP_DATA;
        end else if (b >= WILL_CODE && b <= DONT_CODE) begin
          last_verb = verb_t'(verb_ofs[1:0]);
          parse_state = RXP_CMD;
        end else if (b == SB_CODE) begin
          parse_state = RXP_SUB;
        end else begin
          parse_state = RXP_DATA;
        end
      end
      RXP_CMD: begin
        if (last_verb == VERB_WILL) begin
          expect_reply(hit ? DO_CODE : DONT_CODE, b);
        end else if (last_verb == VERB_DO) begin
          expect_reply(hit ? WILL_CODE : WONT_CODE, b);
        end
        parse_state = RXP_DATA;
      end
      RXP_SUB: begin
        if (b == IAC_CODE) parse_state = RXP_SUBIAC;
      end
      RXP_SUBIAC: begin
        parse_state = (b == SE_CODE) ? RXP_DATA : RXP_SUB;
      end
      default: begin
        if (b == IAC_CODE) parse_state = RXP_IAC;
        else expect_data(b);
      end
    endcase
  endtask

  task automatic check_result();
    parser_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d data=%0d verb=%0d opt=%0d",
                                out_kind, data_byte, reply_verb, reply_option));
    end else begin
      want = expected_results.pop_front();
      if (out_kind !== want.kind)
        report_mismatch($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
      if (data_byte !== want.data)
        report_mismatch($sformatf("data_byte %0d, want %0d", data_byte, want.data));
      if (reply_verb !== want.verb)
        report_mismatch($sformatf("reply_verb %0d, want %0d", reply_verb, want.verb));
      if (reply_option !== want.option)
        report_mismatch($sformatf("reply_option %0d, want %0d", reply_option, want.option));
    end
  endtask

  // Driver: predict on each accepted transaction, then offer the next byte
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || !rx_stall) begin
      if (rx_valid) parse_rx_byte(rx_byte);
      if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_valid <= 1'b1;
        rx_byte <= rx_backlog.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    forever begin
      @(hold_kick);
      @(posedge clk);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_bytes(input logic [7:0] bytes[]);
    foreach (bytes[i]) rx_backlog.push_back(bytes[i]);
  endtask

  // Hold until every byte is taken and every result has come out
  task automatic drain();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || rx_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_option(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_OPT_A) accept_a = value;
    else accept_b = value;
  endtask

  task automatic set_options(input logic [7:0] a, input logic [7:0] b);
    write_option(CFG_OPT_A, a);
    write_option(CFG_OPT_B, b);
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(3))
      0: return accept_a;
      1: return accept_b;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One well-formed sequence with random content, or a little noise
  task automatic queue_random_sequence();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      rx_backlog.push_back(8'($urandom_range(254)));
    end else if (pick < 38) begin
      queue_bytes('{IAC_CODE, IAC_CODE});
    end else if (pick < 70) begin
      b = WILL_CODE + 8'($urandom_range(3));
      queue_bytes('{IAC_CODE, b, pick_option()});
    end else if (pick < 80) begin
      queue_bytes('{IAC_CODE, SB_CODE});
      len = $urandom_range(6);
      repeat (len) begin
        b = 8'($urandom_range(255));
        rx_backlog.push_back(b);
        if (b == IAC_CODE) begin
          b = 8'($urandom_range(255));
          rx_backlog.push_back(b == SE_CODE ? IAC_CODE : b);
        end
      end
      queue_bytes('{IAC_CODE, SE_CODE});
    end else if (pick < 88) begin
      queue_bytes('{IAC_CODE, 8'($urandom_range(249))});
    end else begin
      len = $urandom_range(1, 3);
      repeat (len) rx_backlog.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct);
    int unsigned target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = rx_backlog.size() + count;
    while (rx_backlog.size() < target) queue_random_sequence();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset option values, then every verb and the doubled IAC
    queue_bytes('{8'h00, 8'hFE, IAC_CODE, IAC_CODE,
                  IAC_CODE, DO_CODE, 8'd1, IAC_CODE, WILL_CODE, 8'd255,
                  IAC_CODE, WONT_CODE, 8'd1, IAC_CODE, DONT_CODE, 8'd3});
    drain();

    // Extreme option codes, subnegotiation with IAC inside, lone SE, other command
    set_options(8'd0, 8'd255);
    queue_bytes('{IAC_CODE, WILL_CODE, 8'd0, IAC_CODE, DO_CODE, 8'd7,
                  IAC_CODE, SB_CODE, IAC_CODE, IAC_CODE, IAC_CODE, SE_CODE,
                  IAC_CODE, SE_CODE, IAC_CODE, 8'd241});
    drain();

    run_random(150, 0, 0);
    set_options(8'd255, 8'd0);
    run_random(150, 65, 0);
    set_options(8'd7, 8'd7);
    run_random(150, 0, 65);
    set_options(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(150, 16, 16);

    // Back the block up behind a stalled receiver
    set_options(8'($urandom_range(255)), 8'($urandom_range(255)));
    -> hold_kick;
    run_random(100, 0, 0);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
